[hdl/vector3_normalize_core_assert.svh]
// Assertion macros used by the vector normalizer merge stage.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef VECTOR3_NORMALIZE_CORE_ASSERT_SVH
`define VECTOR3_NORMALIZE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define VN_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define VN_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define VN_ASSERT_ALWAYS(lbl, cond, msg)
`define VN_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[hdl/vn_pkg.sv]
// Types and widths shared by the vector normalizer.
// No dependencies.
`timescale 1ns / 1ps
package vn_pkg;
   localparam int IN_W      = 32;
   localparam int FRAC_W    = 30;
   localparam int OUT_W     = FRAC_W + 2;
   localparam int QUO_W     = FRAC_W + 1;
   localparam int SQ_W      = 2 * IN_W;
   localparam int SUM_W     = SQ_W + 2;
   localparam int TGT_W     = SQ_W + 2 * FRAC_W;
   localparam int CMP_W     = 2 * FRAC_W + SUM_W + 2;
   localparam int LANES     = 3;

   typedef struct packed {
      logic signed [IN_W-1:0] vec_x;
      logic signed [IN_W-1:0] vec_y;
      logic signed [IN_W-1:0] vec_z;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] unit_x;
      logic signed [OUT_W-1:0] unit_y;
      logic signed [OUT_W-1:0] unit_z;
      logic                    zero_length;
   } rsp_word_type;

   typedef struct packed {
      logic valid;
      logic neg;
      logic zero;
   } lane_ctl_type;
endpackage

[hdl/vn_prep.sv]
// Front end: magnitudes, squares, sum of squares and per-lane targets.
// Depends on vn_pkg.
`timescale 1ns / 1ps
module vn_prep (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  vn_pkg::req_word_type              in_word,
   output vn_pkg::lane_ctl_type              out_ctl [vn_pkg::LANES],
   output logic [vn_pkg::SUM_W-1:0]          out_sum,
   output logic [vn_pkg::TGT_W-1:0]          out_target [vn_pkg::LANES]
);
   logic [vn_pkg::IN_W-1:0] raw [vn_pkg::LANES];
   logic [vn_pkg::IN_W-1:0] mag_ff [vn_pkg::LANES], mag_in [vn_pkg::LANES];
   logic [vn_pkg::LANES-1:0] neg_ff, neg_in, neg1_ff, neg2_ff;
   logic [vn_pkg::SQ_W-1:0] sq_ff [vn_pkg::LANES];
   logic [vn_pkg::SUM_W-1:0] sum_ff;
   logic [vn_pkg::TGT_W-1:0] tgt_ff [vn_pkg::LANES];
   logic [2:0] valid_ff;
   logic zero1_ff, zero2_ff, zero_in;

   assign raw[0] = in_word.vec_x;
   assign raw[1] = in_word.vec_y;
   assign raw[2] = in_word.vec_z;

   always_comb begin
      for (int i = 0; i < vn_pkg::LANES; i++) begin
         neg_in[i] = raw[i][vn_pkg::IN_W-1];
         mag_in[i] = neg_in[i] ? (~raw[i] + 1'b1) : raw[i];
      end
      zero_in = (mag_ff[0] == '0) && (mag_ff[1] == '0) && (mag_ff[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      neg1_ff  <= neg_ff;
      neg2_ff  <= neg1_ff;
      zero1_ff <= zero_in;
      zero2_ff <= zero1_ff;
      sum_ff   <= vn_pkg::SUM_W'(sq_ff[0]) + vn_pkg::SUM_W'(sq_ff[1])
                + vn_pkg::SUM_W'(sq_ff[2]);
      for (int i = 0; i < vn_pkg::LANES; i++) begin
         mag_ff[i] <= mag_in[i];
         sq_ff[i]  <= mag_ff[i] * mag_ff[i];
         tgt_ff[i] <= vn_pkg::TGT_W'(sq_ff[i]) << (2 * vn_pkg::FRAC_W);
      end
   end

   assign out_sum = sum_ff;
   always_comb begin
      for (int i = 0; i < vn_pkg::LANES; i++) begin
         out_ctl[i].valid = valid_ff[2];
         out_ctl[i].neg   = neg2_ff[i];
         out_ctl[i].zero  = zero2_ff;
         out_target[i]    = tgt_ff[i];
      end
   end
endmodule

[hdl/vn_lane.sv]
// One lane: restoring bit-serial search of floor(m * 2^F / sqrt(S)), one bit per stage.
// Depends on vn_pkg.
`timescale 1ns / 1ps
module vn_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  vn_pkg::lane_ctl_type         in_ctl,
   input  logic [vn_pkg::SUM_W-1:0]     in_sum,
   input  logic [vn_pkg::TGT_W-1:0]     in_target,
   output vn_pkg::lane_ctl_type         out_ctl,
   output logic [vn_pkg::QUO_W-1:0]     out_quo
);
   localparam int STEPS = vn_pkg::FRAC_W + 1;

   // rem = target - q^2*S, acc = q*S
   logic [vn_pkg::CMP_W-1:0] rem_ff [STEPS+1];
   logic [vn_pkg::CMP_W-1:0] acc_ff [STEPS+1];
   logic [vn_pkg::CMP_W-1:0] sum_ff [STEPS+1];
   logic [vn_pkg::QUO_W-1:0] quo_ff [STEPS+1];
   logic [STEPS:0]           valid_ff;
   logic [STEPS:0]           neg_ff, zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= vn_pkg::CMP_W'(in_target);
      acc_ff[0]  <= '0;
      sum_ff[0]  <= vn_pkg::CMP_W'(in_sum);
      quo_ff[0]  <= '0;
      neg_ff[0]  <= in_ctl.neg;
      zero_ff[0] <= in_ctl.zero;
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int BIT = vn_pkg::FRAC_W - k;
      logic [vn_pkg::CMP_W-1:0] incr;
      logic                     take;

      // (q + 2^b)^2 S - q^2 S = 2^(b+1) qS + 2^(2b) S
      assign incr = (acc_ff[k] << (BIT + 1)) + (sum_ff[k] << (2 * BIT));
      assign take = (incr <= rem_ff[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= take ? (rem_ff[k] - incr) : rem_ff[k];
         acc_ff[k+1]  <= take ? (acc_ff[k] + (sum_ff[k] << BIT)) : acc_ff[k];
         quo_ff[k+1]  <= take ? (quo_ff[k] | (vn_pkg::QUO_W'(1) << BIT)) : quo_ff[k];
         sum_ff[k+1]  <= sum_ff[k];
         neg_ff[k+1]  <= neg_ff[k];
         zero_ff[k+1] <= zero_ff[k];
      end
   end

   assign out_ctl.valid = valid_ff[STEPS];
   assign out_ctl.neg   = neg_ff[STEPS];
   assign out_ctl.zero  = zero_ff[STEPS];
   assign out_quo       = quo_ff[STEPS];
endmodule

[hdl/vn_merge.sv]
// Merge stage: apply signs, force the zero vector, register the result word.
// Depends on vn_pkg and the assertion header.
`timescale 1ns / 1ps
`include "vector3_normalize_core_assert.svh"
module vn_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  vn_pkg::lane_ctl_type      in_ctl [vn_pkg::LANES],
   input  logic [vn_pkg::QUO_W-1:0]  in_quo [vn_pkg::LANES],
   output logic                      out_strobe,
   output vn_pkg::rsp_word_type      out_word
);
   logic [vn_pkg::OUT_W-1:0] unit_in [vn_pkg::LANES];
   logic                     strobe_ff;
   vn_pkg::rsp_word_type     word_ff, word_in;

   always_comb begin
      for (int i = 0; i < vn_pkg::LANES; i++) begin
         unit_in[i] = vn_pkg::OUT_W'(in_quo[i]);
         if (in_ctl[i].zero) begin
            unit_in[i] = '0;
         end else if (in_ctl[i].neg) begin
            unit_in[i] = ~unit_in[i] + 1'b1;
         end
      end
      word_in.unit_x      = unit_in[0];
      word_in.unit_y      = unit_in[1];
      word_in.unit_z      = unit_in[2];
      word_in.zero_length = in_ctl[0].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_ctl[0].valid;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_strobe = strobe_ff;
   assign out_word   = word_ff;

   `VN_ASSERT_NEXT(a_strobe_follows, in_ctl[0].valid, out_strobe, "result word dropped")
   `VN_ASSERT_NEXT(a_no_spurious, !in_ctl[0].valid, !out_strobe, "result word invented")
   `VN_ASSERT_ALWAYS(a_zero_clean, !(out_strobe && out_word.zero_length) || (out_word.unit_x == '0 && out_word.unit_y == '0 && out_word.unit_z == '0), "zero vector not cleared")
   `VN_ASSERT_ALWAYS(a_lanes_aligned, (in_ctl[0].valid == in_ctl[1].valid) && (in_ctl[1].valid == in_ctl[2].valid), "lanes out of step")
endmodule

[hdl/vector3_normalize_core.sv]
// Vector normalizer top level: front end, three component lanes, merge stage.
// Depends on vn_pkg, vn_prep, vn_lane and vn_merge.
//
// Usage:
//   Drive req_word (x, y, z as signed Q16.16) and raise start; the word is
//   taken at any clock edge with start high and busy low. busy is high only
//   during reset and in the cycle after it, so one word may enter every cycle.
//   Each word yields one result word on rsp_word (unit x, y, z as signed
//   Q2.30, truncated toward zero, plus zero_length) with rsp_strobe high for
//   exactly one cycle.
//   Throughput is one word per cycle: the front end (magnitude, square,
//   sum) takes three stages, each lane resolves one quotient bit per stage
//   over 31 stages plus an entry register, and the merge stage registers
//   the signed result.
//   The receiver cannot stall; results must be taken when strobed.
//   Synchronous reset clears all valid bits; words in flight are dropped.
//   A zero vector gives zero components with zero_length set.
`timescale 1ns / 1ps
module vector3_normalize_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  vn_pkg::req_word_type req_word,
   output logic                 rsp_strobe,
   output vn_pkg::rsp_word_type rsp_word
);
   vn_pkg::lane_ctl_type      prep_ctl [vn_pkg::LANES];
   vn_pkg::lane_ctl_type      lane_ctl [vn_pkg::LANES];
   logic [vn_pkg::SUM_W-1:0]  prep_sum;
   logic [vn_pkg::TGT_W-1:0]  prep_target [vn_pkg::LANES];
   logic [vn_pkg::QUO_W-1:0]  lane_quo [vn_pkg::LANES];
   logic                      busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end
   assign busy = busy_ff;

   vn_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start && !busy_ff),
      .in_word    (req_word),
      .out_ctl    (prep_ctl),
      .out_sum    (prep_sum),
      .out_target (prep_target)
   );

   for (genvar i = 0; i < vn_pkg::LANES; i++) begin : g_lane
      vn_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (prep_ctl[i]),
         .in_sum    (prep_sum),
         .in_target (prep_target[i]),
         .out_ctl   (lane_ctl[i]),
         .out_quo   (lane_quo[i])
      );
   end

   vn_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_ctl     (lane_ctl),
      .in_quo     (lane_quo),
      .out_strobe (rsp_strobe),
      .out_word   (rsp_word)
   );
endmodule

[bench/tb.sv]
// Self-checking bench for vector3_normalize_core: drives vectors, predicts unit vectors.
// Depends on vn_pkg and the vector3_normalize_core RTL.
`timescale 1ns / 1ps
module tb;
   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   vn_pkg::req_word_type req_word;
   logic                 rsp_strobe;
   vn_pkg::rsp_word_type rsp_word;

   vn_pkg::req_word_type pending_vectors[$];
   vn_pkg::rsp_word_type expected_units[$];
   int                   error_count;
   int                   result_count;
   int                   idle_left;

   vector3_normalize_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // floor(|c| * 2^FRAC_W / length), signed, found bit by bit by exact comparison
   function automatic logic [vn_pkg::OUT_W-1:0] unit_component(
      logic [vn_pkg::IN_W-1:0] comp, logic [159:0] sum_sq);
      logic [159:0] mag;
      logic [159:0] tgt;
      logic [159:0] cand;
      logic [159:0] lhs;
      logic [159:0] quo;
      quo = '0;
      mag = comp[vn_pkg::IN_W-1] ? {128'd0, -comp} : {128'd0, comp};
      tgt = (mag * mag) << (2 * vn_pkg::FRAC_W);
      for (int b = vn_pkg::FRAC_W; b >= 0; b--) begin
         cand = quo | (160'd1 << b);
         lhs = cand * cand * sum_sq;
         if (lhs <= tgt) quo = cand;
      end
      return comp[vn_pkg::IN_W-1] ? -quo[vn_pkg::OUT_W-1:0] : quo[vn_pkg::OUT_W-1:0];
   endfunction

   function automatic vn_pkg::rsp_word_type normalize_vector(vn_pkg::req_word_type v);
      vn_pkg::rsp_word_type r;
      logic [159:0] mx;
      logic [159:0] my;
      logic [159:0] mz;
      logic [159:0] sum_sq;
      mx = v.vec_x[vn_pkg::IN_W-1] ? {128'd0, -v.vec_x} : {128'd0, v.vec_x};
      my = v.vec_y[vn_pkg::IN_W-1] ? {128'd0, -v.vec_y} : {128'd0, v.vec_y};
      mz = v.vec_z[vn_pkg::IN_W-1] ? {128'd0, -v.vec_z} : {128'd0, v.vec_z};
      sum_sq = mx * mx + my * my + mz * mz;
      r = '0;
      if (sum_sq == 0) begin
         r.zero_length = 1'b1;
      end else begin
         r.unit_x = unit_component(v.vec_x, sum_sq);
         r.unit_y = unit_component(v.vec_y, sum_sq);
         r.unit_z = unit_component(v.vec_z, sum_sq);
      end
      return r;
   endfunction

   task automatic report(string field, logic [vn_pkg::OUT_W-1:0] got,
                         logic [vn_pkg::OUT_W-1:0] want);
      error_count++;
      $display("mismatch word %0d %s: got %h want %h", result_count, field, got, want);
   endtask

   // driver: a word moves on an edge with start high and busy low
   always @(posedge clock) begin
      bit take;
      bit drive;
      if (reset) begin
         start    <= 1'b0;
         req_word <= '0;
         idle_left = 0;
      end else begin
         take = start && !busy;
         if (take) begin
            expected_units.push_back(normalize_vector(req_word));
            void'(pending_vectors.pop_front());
         end
         drive = 1'b0;
         if (idle_left > 0) begin
            idle_left--;
         end else if (pending_vectors.size() > 0) begin
            if (pending_vectors.size() > 150 && $urandom_range(0, 9) == 0)
               idle_left = $urandom_range(1, 11) - 1;
            else
               drive = 1'b1;
         end
         if (drive) req_word <= pending_vectors[0];
         start <= drive;
      end
   end

   // monitor: results cannot be held off, check each one as it is strobed
   always @(posedge clock) begin
      vn_pkg::rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (expected_units.size() == 0) begin
            report("unexpected", rsp_word.unit_x, '0);
         end else begin
            want = expected_units.pop_front();
            if (rsp_word.unit_x !== want.unit_x) report("unit_x", rsp_word.unit_x, want.unit_x);
            if (rsp_word.unit_y !== want.unit_y) report("unit_y", rsp_word.unit_y, want.unit_y);
            if (rsp_word.unit_z !== want.unit_z) report("unit_z", rsp_word.unit_z, want.unit_z);
            if (rsp_word.zero_length !== want.zero_length)
               report("zero_length", {{(vn_pkg::OUT_W-1){1'b0}}, rsp_word.zero_length},
                      {{(vn_pkg::OUT_W-1){1'b0}}, want.zero_length});
         end
         result_count++;
      end
   end

   function automatic logic [vn_pkg::IN_W-1:0] random_component();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 255) - 128;
         2: return 32'd0;
         3: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
         4: return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 15)
                                        : 32'h7fff_ffff - $urandom_range(0, 15);
         default: return $signed($urandom()) >>> $urandom_range(0, 31);
      endcase
   endfunction

   task automatic add_vector(logic [vn_pkg::IN_W-1:0] x, logic [vn_pkg::IN_W-1:0] y,
                             logic [vn_pkg::IN_W-1:0] z);
      vn_pkg::req_word_type v;
      v.vec_x = x;
      v.vec_y = y;
      v.vec_z = z;
      pending_vectors.push_back(v);
   endtask

   initial begin
      error_count = 0;
      result_count = 0;
      reset = 1'b1;
      // zero vector, axes, extremes, small values
      add_vector(0, 0, 0);
      add_vector(32'h0001_0000, 0, 0);
      add_vector(0, 32'hffff_0000, 0);
      add_vector(0, 0, 32'h7fff_ffff);
      add_vector(32'h8000_0000, 0, 0);
      add_vector(0, 32'h8000_0000, 0);
      add_vector(0, 0, 32'h8000_0000);
      add_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      add_vector(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      add_vector(1, 0, 0);
      add_vector(32'hffff_ffff, 0, 0);
      add_vector(1, 1, 1);
      add_vector(-1, -1, -1);
      add_vector(3, 4, 0);
      add_vector(32'h0003_0000, 32'hfffc_0000, 32'h000c_0000);
      add_vector(1, 32'h7fff_ffff, 0);
      add_vector(32'h8000_0000, 1, 32'hffff_ffff);
      add_vector(0, 0, 0);
      repeat (1430) add_vector(random_component(), random_component(), random_component());
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (pending_vectors.size() == 0 && expected_units.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0 && expected_units.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("tb NOT OK");
      $finish;
   end
endmodule
